// File: hw/rtl/kmp_pattern_search_core_assert.svh
// Assertion macros for the KMP pattern search core.
// Included by files that check their own logic; expects clk and rst_n in scope.
`ifndef KMP_PATTERN_SEARCH_CORE_ASSERT_SVH
`define KMP_PATTERN_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define KMPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmp_pattern_search_core: assertion failed");
// Next-cycle implication, disabled during reset.
`define KMPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmp_pattern_search_core: assertion failed");
`else
`define KMPS_ASSERT_NOW(label, ante, cons)
`define KMPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/kmps_pkg.sv
// Shared types and constants of the KMP pattern search core.
// No dependencies; used by the interfaces, the link walker and the top level.
package kmps_pkg;

    localparam int MAX_PATTERN_DEF    = 64;
    localparam int POSITION_WIDTH_DEF = 32;

    localparam int SYMBOL_W  = 8;
    localparam int STATUS_W  = 2;
    localparam int POS_OUT_W = 32;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_MATCH    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

    // Command from the top level to the link walker.
    typedef struct packed {
        logic start;
        logic build;
    } walk_cmd_t;

    // Status from the link walker back to the top level.
    typedef struct packed {
        logic done;
        logic reached;
    } walk_stat_t;

endpackage

// File: hw/rtl/kmps_if.sv
// Handshake interfaces of the KMP pattern search core: input words and results.
// Depends on kmps_pkg for field widths.
interface kmps_feed_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [kmps_pkg::SYMBOL_W-1:0] symbol;
    logic                          last;

    modport source (output valid, operation, symbol, last, input ready);
    modport sink   (input valid, operation, symbol, last, output ready);
endinterface

interface kmps_result_if;
    logic                           valid;
    logic                           ready;
    logic [kmps_pkg::STATUS_W-1:0]  status;
    logic [kmps_pkg::POS_OUT_W-1:0] position;

    modport source (output valid, status, position, input ready);
    modport sink   (input valid, status, position, output ready);
endinterface

// File: hw/rtl/kmps_link_walk.sv
// Shared compare unit of the KMP core: holds the pattern and failure memories and
// walks failure links one step per cycle. Depends on kmps_pkg.
module kmps_link_walk #(
    parameter int  MAX_PATTERN = kmps_pkg::MAX_PATTERN_DEF,
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kmps_pkg::walk_cmd_t           cmd,
    input  logic [kmps_pkg::SYMBOL_W-1:0] sym,
    input  logic [LEN_W-1:0]              cur,
    input  logic [LEN_W-1:0]              bound,
    output kmps_pkg::walk_stat_t          stat,
    output logic [LEN_W-1:0]              len
);
    import kmps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                state_reg, state_next;
    logic                build_reg;
    logic [SYMBOL_W-1:0] sym_reg;
    logic [LEN_W-1:0]    bound_reg;
    logic [LEN_W-1:0]    cur_reg, cur_next;

    logic [SYMBOL_W-1:0] store_mem [MAX_PATTERN];
    logic [LEN_W-1:0]    fail_mem  [MAX_PATTERN];
    logic [SYMBOL_W-1:0] store_q_reg;
    logic [LEN_W-1:0]    fail_q_reg;

    logic [LEN_W-1:0]    rd_len, rd_len_dec;
    logic [IDX_W-1:0]    store_raddr, fail_raddr;
    logic                in_range, equal, mismatch;

    // The candidate length is compared against the stored byte at that length;
    // on a mismatch the failure entry just read becomes the next candidate.
    assign in_range = cur_reg < bound_reg;
    assign equal    = sym_reg == store_q_reg;
    assign mismatch = (state_reg == ST_WALK) && (cur_reg != '0) && in_range && !equal;

    assign rd_len      = cmd.start ? cur : fail_q_reg;
    assign rd_len_dec  = rd_len - LEN_W'(1);
    assign store_raddr = rd_len[IDX_W-1:0];
    assign fail_raddr  = rd_len_dec[IDX_W-1:0];

    assign len          = cur_reg + LEN_W'(in_range && equal);
    assign stat.done    = (state_reg == ST_WALK) && !mismatch;
    assign stat.reached = len >= bound_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!mismatch)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.start)
        begin
            cur_next = cur;
        end
        else if (mismatch)
        begin
            cur_next = fail_q_reg;
        end
        else
        begin
            cur_next = cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.start)
        begin
            build_reg <= cmd.build;
            sym_reg   <= sym;
            bound_reg <= bound;
        end
    end

    // While building, the new byte goes in at the current length and its
    // failure entry is written when the walk settles.
    always_ff @(posedge clk)
    begin
        if (cmd.start && cmd.build)
        begin
            store_mem[bound[IDX_W-1:0]] <= sym;
        end
        if (stat.done && build_reg)
        begin
            fail_mem[bound_reg[IDX_W-1:0]] <= len;
        end
        store_q_reg <= store_mem[store_raddr];
        fail_q_reg  <= fail_mem[fail_raddr];
    end

endmodule

// File: hw/rtl/kmp_pattern_search_core.sv
// Top level of the KMP pattern search core: word handshakes, search state and result register.
// Depends on kmps_pkg, kmps_if.sv, kmps_link_walk and kmp_pattern_search_core_assert.svh.
//
//   Channel   Direction  Word contents
//   feed      sink       operation (pattern/text), symbol byte, last marker
//   result    source     status code, 32-bit match start position
//
// A stored pattern word or a searched text word keeps the input busy while failure links
// are followed; the single read port of each memory in the link walker sets one link per
// cycle. Dropped pattern words and text words that are not searched start no walk.
// Reset is asynchronous and active low; the pattern and failure memories are not cleared,
// only the lengths, the text index and the flags. A new word is taken while a result waits,
// as long as the result register drains in the same cycle or is empty.
module kmp_pattern_search_core #(
    parameter int MAX_PATTERN    = kmps_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_WIDTH = kmps_pkg::POSITION_WIDTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    kmps_feed_if.sink    feed,
    kmps_result_if.source result
);
    import kmps_pkg::*;

    `include "kmp_pattern_search_core_assert.svh"

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // Search state.
    logic                      busy_reg, busy_next;
    logic                      op_reg, last_reg;
    logic [LEN_W-1:0]          pattern_length_reg, pattern_length_next;
    logic [LEN_W-1:0]          prefix_length_reg, prefix_length_next;
    logic [LEN_W-1:0]          match_length_reg, match_length_next;
    logic [POSITION_WIDTH-1:0] text_index_reg, text_index_next;
    logic                      match_done_reg, match_done_next;
    logic                      pattern_overflow_reg, pattern_overflow_next;
    logic                      pattern_closed_reg, pattern_closed_next;

    // Result register.
    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       out_status_reg, out_status_next;
    logic [POSITION_WIDTH-1:0] out_position_reg, out_position_next;
    logic [POSITION_WIDTH+POS_OUT_W-1:0] pos_ext;

    // Link walker connection.
    walk_cmd_t                 walk_cmd;
    walk_stat_t                walk_stat;
    logic [LEN_W-1:0]          walk_cur, walk_bound, walk_len;

    logic                      in_fire;
    logic [LEN_W-1:0]          eff_len, eff_prefix;
    logic                      eff_overflow;
    logic                      text_step, step_last, step_hit;
    logic [POSITION_WIDTH+LEN_W-1:0] start_wide;

    kmps_link_walk #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (walk_cmd),
        .sym   (feed.symbol),
        .cur   (walk_cur),
        .bound (walk_bound),
        .stat  (walk_stat),
        .len   (walk_len)
    );

    // A word is taken when no walk is running and the result slot is free or
    // draining; only the word in progress can fill the slot afterwards.
    assign feed.ready = !busy_reg && (!out_valid_reg || result.ready);
    assign in_fire    = feed.valid && feed.ready;

    assign result.valid  = out_valid_reg;
    assign result.status = out_status_reg;
    assign pos_ext         = {{POS_OUT_W{1'b0}}, out_position_reg};
    assign result.position = pos_ext[POS_OUT_W-1:0];

    // A pattern word after a closed pattern starts a fresh one.
    assign eff_len      = pattern_closed_reg ? '0 : pattern_length_reg;
    assign eff_prefix   = pattern_closed_reg ? '0 : prefix_length_reg;
    assign eff_overflow = pattern_closed_reg ? 1'b0 : pattern_overflow_reg;

    // Text walks resume from the running match length against the whole pattern;
    // pattern walks resume from the running prefix against the bytes stored so far.
    assign walk_cur   = (feed.operation == OP_TEXT) ? match_length_reg : eff_prefix;
    assign walk_bound = (feed.operation == OP_TEXT) ? pattern_length_reg : eff_len;

    // Match start, wrapped to the position width.
    assign start_wide = {{LEN_W{1'b0}}, text_index_reg} + (POSITION_WIDTH + LEN_W)'(1)
                      - {{POSITION_WIDTH{1'b0}}, pattern_length_reg};

    always_comb
    begin
        busy_next             = busy_reg;
        pattern_length_next   = pattern_length_reg;
        prefix_length_next    = prefix_length_reg;
        match_length_next     = match_length_reg;
        text_index_next       = text_index_reg;
        match_done_next       = match_done_reg;
        pattern_overflow_next = pattern_overflow_reg;
        pattern_closed_next   = pattern_closed_reg;
        out_valid_next        = out_valid_reg && !result.ready;
        out_status_next       = out_status_reg;
        out_position_next     = out_position_reg;
        walk_cmd              = '0;
        text_step             = 1'b0;
        step_last             = 1'b0;
        step_hit              = 1'b0;

        if (in_fire)
        begin
            walk_cmd.build = (feed.operation == OP_PATTERN);
            if (feed.operation == OP_TEXT)
            begin
                pattern_closed_next = 1'b1;
                if (!match_done_reg && !pattern_overflow_reg && pattern_length_reg != '0)
                begin
                    walk_cmd.start = 1'b1;
                    busy_next      = 1'b1;
                end
                else
                begin
                    // Nothing to search: only the index moves and the end is handled.
                    text_step = 1'b1;
                    step_last = feed.last;
                end
            end
            else
            begin
                pattern_closed_next   = feed.last;
                pattern_length_next   = eff_len;
                prefix_length_next    = eff_prefix;
                pattern_overflow_next = eff_overflow;
                if (eff_len < LEN_W'(MAX_PATTERN))
                begin
                    walk_cmd.start = 1'b1;
                    busy_next      = 1'b1;
                end
                else
                begin
                    // The store is full: the byte is dropped and the pattern marked.
                    pattern_overflow_next = 1'b1;
                    if (feed.last)
                    begin
                        out_valid_next    = 1'b1;
                        out_status_next   = STATUS_TOO_LONG;
                        out_position_next = '0;
                    end
                end
            end
        end

        if (walk_stat.done)
        begin
            busy_next = 1'b0;
            if (op_reg == OP_PATTERN)
            begin
                pattern_length_next = pattern_length_reg + LEN_W'(1);
                prefix_length_next  = walk_len;
            end
            else
            begin
                match_length_next = walk_len;
                text_step         = 1'b1;
                step_last         = last_reg;
                step_hit          = walk_stat.reached;
            end
        end

        if (text_step)
        begin
            if (step_hit)
            begin
                out_valid_next    = 1'b1;
                out_status_next   = STATUS_MATCH;
                out_position_next = start_wide[POSITION_WIDTH-1:0];
                match_done_next   = 1'b1;
            end
            text_index_next = text_index_reg + POSITION_WIDTH'(1);
            if (step_last)
            begin
                if (!step_hit && !match_done_reg)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = pattern_overflow_reg ? STATUS_TOO_LONG
                                                             : STATUS_NO_MATCH;
                    out_position_next = '0;
                end
                match_length_next = '0;
                text_index_next   = '0;
                match_done_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg             <= 1'b0;
            pattern_length_reg   <= '0;
            prefix_length_reg    <= '0;
            match_length_reg     <= '0;
            text_index_reg       <= '0;
            match_done_reg       <= 1'b0;
            pattern_overflow_reg <= 1'b0;
            pattern_closed_reg   <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            busy_reg             <= busy_next;
            pattern_length_reg   <= pattern_length_next;
            prefix_length_reg    <= prefix_length_next;
            match_length_reg     <= match_length_next;
            text_index_reg       <= text_index_next;
            match_done_reg       <= match_done_next;
            pattern_overflow_reg <= pattern_overflow_next;
            pattern_closed_reg   <= pattern_closed_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    // Word attributes held for the walk, and the result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= feed.operation;
            last_reg <= feed.last;
        end
        out_status_reg   <= out_status_next;
        out_position_reg <= out_position_next;
    end

    // The walker only finishes a walk that this level started and still waits on.
    `KMPS_ASSERT_NOW(a_done_while_busy, walk_stat.done, busy_reg)
    // The running prefix is always a proper prefix of the stored pattern.
    `KMPS_ASSERT_NOW(a_prefix_proper, !busy_reg && pattern_length_reg != '0, prefix_length_reg < pattern_length_reg)
    // Overflow is flagged only once the store is completely full.
    `KMPS_ASSERT_NOW(a_overflow_full, pattern_overflow_reg, pattern_length_reg == LEN_W'(MAX_PATTERN))

endmodule

// File: tb/sv/kmps_match_checker.sv
`timescale 1ns / 1ps
// Result checker for the KMP pattern search core: predicts each result from the accepted words.
// Depends on kmps_pkg; watches the feed and result channels that the testbench top connects.
module kmps_match_checker #(
    parameter int MAX_PATTERN = kmps_pkg::MAX_PATTERN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           feed_valid,
    input  logic                           feed_ready,
    input  logic                           feed_operation,
    input  logic [kmps_pkg::SYMBOL_W-1:0]  feed_symbol,
    input  logic                           feed_last,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  logic [kmps_pkg::STATUS_W-1:0]  result_status,
    input  logic [kmps_pkg::POS_OUT_W-1:0] result_position,
    output int                             fail_count,
    output int                             pending_count
);
    import kmps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [POS_OUT_W-1:0] position;
    } search_result_t;

    // Shadow copy of the search state.
    logic [SYMBOL_W-1:0] shadow_pattern [MAX_PATTERN];
    logic [LEN_W-1:0]    shadow_links   [MAX_PATTERN];
    logic [LEN_W-1:0]    loaded_len;
    logic [LEN_W-1:0]    border_len;
    logic [LEN_W-1:0]    matched_len;
    logic [31:0]         text_pos;
    bit                  found_flag;
    bit                  too_long_flag;
    bit                  pattern_shut;

    search_result_t expected_results [$];
    search_result_t oldest;
    search_result_t predicted;
    bit             produces;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Advances the shadow state by one accepted word and tells whether it gives a result.
    function automatic void predict_search_word(input logic op, input logic [SYMBOL_W-1:0] sym,
                                                input logic last, output bit has_result,
                                                output search_result_t res);
        logic [LEN_W-1:0] slot;
        has_result = 1'b0;
        res        = '0;
        if (op == OP_PATTERN)
        begin
            if (pattern_shut)
            begin
                loaded_len    = '0;
                border_len    = '0;
                too_long_flag = 1'b0;
                pattern_shut  = 1'b0;
            end
            if (loaded_len < MAX_PATTERN)
            begin
                slot = loaded_len;
                shadow_pattern[slot] = sym;
                if (slot == 0)
                    border_len = '0;
                else
                begin
                    while (border_len > 0 && sym != shadow_pattern[border_len])
                        border_len = shadow_links[border_len - 1];
                    if (sym == shadow_pattern[border_len])
                        border_len = border_len + 1'b1;
                end
                shadow_links[slot] = border_len;
                loaded_len = slot + 1'b1;
            end
            else
                too_long_flag = 1'b1;
            if (last)
            begin
                pattern_shut = 1'b1;
                if (too_long_flag)
                begin
                    has_result   = 1'b1;
                    res.status   = STATUS_TOO_LONG;
                end
            end
        end
        else
        begin
            pattern_shut = 1'b1;
            if (!found_flag && !too_long_flag && loaded_len > 0)
            begin
                while (matched_len > 0 && matched_len < loaded_len &&
                       sym != shadow_pattern[matched_len])
                    matched_len = shadow_links[matched_len - 1];
                if (matched_len < loaded_len && sym == shadow_pattern[matched_len])
                    matched_len = matched_len + 1'b1;
                if (matched_len >= loaded_len)
                begin
                    has_result   = 1'b1;
                    res.status   = STATUS_MATCH;
                    res.position = text_pos + 32'd1 - 32'(loaded_len);
                    found_flag   = 1'b1;
                end
            end
            text_pos = text_pos + 32'd1;
            if (last)
            begin
                if (!found_flag)
                begin
                    has_result = 1'b1;
                    res.status = too_long_flag ? STATUS_TOO_LONG : STATUS_NO_MATCH;
                end
                matched_len = '0;
                text_pos    = '0;
                found_flag  = 1'b0;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_len    = '0;
            border_len    = '0;
            matched_len   = '0;
            text_pos      = '0;
            found_flag    = 1'b0;
            too_long_flag = 1'b0;
            pattern_shut  = 1'b0;
            expected_results.delete();
            pending_count = 0;
            fail_count    = 0;
        end
        else
        begin
            // A result can never stem from the word taken at the same edge.
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result: status %0d position %0d",
                                              result_status, result_position));
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result_status !== oldest.status)
                        report_mismatch($sformatf("status is %0d, expected %0d",
                                                  result_status, oldest.status));
                    if (result_position !== oldest.position)
                        report_mismatch($sformatf("position is %0d, expected %0d",
                                                  result_position, oldest.position));
                end
            end
            if (feed_valid && feed_ready)
            begin
                predict_search_word(feed_operation, feed_symbol, feed_last, produces, predicted);
                if (produces)
                    expected_results.push_back(predicted);
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// File: tb/sv/kmp_pattern_search_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the KMP pattern search core: clock, reset, word stimulus and verdict.
// Depends on kmps_pkg, kmps_if.sv, the core itself and kmps_match_checker.
module kmp_pattern_search_core_tb;
    import kmps_pkg::*;

    // No new random case starts once this many words have been accepted.
    localparam int WORD_TARGET  = 1950;
    // Cycles in a row without any accepted word before the run is declared hung.
    // The longest quiet stretch of a correct run is the long receiver hold-off below
    // plus a full pattern of failure-link walks, both far under this figure.
    localparam int STALL_LIMIT  = 6000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_WORD = 1400;
    localparam int PHASE_ONE    = 650;
    localparam int PHASE_TWO    = 1300;

    logic clk;
    logic rst_n;

    kmps_feed_if   feed_ch ();
    kmps_result_if result_ch ();

    int fail_count;
    int pending_count;
    int words_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;
    int hold_left;
    bit hold_done;

    // Scratch buffers for the pattern and text of one random case.
    logic [SYMBOL_W-1:0] pattern_buf [$];
    logic [SYMBOL_W-1:0] text_buf    [$];

    kmp_pattern_search_core #(
        .MAX_PATTERN    (MAX_PATTERN_DEF),
        .POSITION_WIDTH (POSITION_WIDTH_DEF)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_ch),
        .result (result_ch)
    );

    kmps_match_checker #(
        .MAX_PATTERN (MAX_PATTERN_DEF)
    ) match_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .feed_valid      (feed_ch.valid),
        .feed_ready      (feed_ch.ready),
        .feed_operation  (feed_ch.operation),
        .feed_symbol     (feed_ch.symbol),
        .feed_last       (feed_ch.last),
        .result_valid    (result_ch.valid),
        .result_ready    (result_ch.ready),
        .result_status   (result_ch.status),
        .result_position (result_ch.position),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The idle rates follow the progress of the stimulus: the sender idles rarely and the
    // receiver often at first, then the other way round, and at last neither idles.
    task automatic update_idle_rates();
        if (words_sent < PHASE_ONE)
        begin
            send_idle_pct = 10;
            recv_idle_pct = 59;
        end
        else if (words_sent < PHASE_TWO)
        begin
            send_idle_pct = 59;
            recv_idle_pct = 10;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // Offers one word from a falling edge and returns at the falling edge after it was taken.
    // Valid is only ever assigned once per time step, so a word that follows directly keeps
    // valid high without a glitch.
    task automatic send_word(input logic op, input logic [SYMBOL_W-1:0] sym, input logic last);
        update_idle_rates();
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            feed_ch.valid <= 1'b0;
            @(negedge clk);
        end
        feed_ch.valid     <= 1'b1;
        feed_ch.operation <= op;
        feed_ch.symbol    <= sym;
        feed_ch.last      <= last;
        @(posedge clk);
        while (!feed_ch.ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // Directed words: extremes of the byte, text before any pattern, a match on the last
    // byte, text that arrives while a pattern is still open, bytes after a match, a new
    // pattern after a closed one, and a search that has to follow failure links.
    task automatic run_directed();
        // Text with no pattern loaded yet finds nothing.
        send_word(OP_TEXT, 8'h41, 1'b0);
        send_word(OP_TEXT, 8'h42, 1'b1);
        // One-byte pattern of the lowest byte, matched on the last text byte.
        send_word(OP_PATTERN, 8'h00, 1'b1);
        send_word(OP_TEXT, 8'hFF, 1'b0);
        send_word(OP_TEXT, 8'h00, 1'b1);
        // An open pattern of the highest byte is closed by text; the byte after the
        // match is ignored.
        send_word(OP_PATTERN, 8'hFF, 1'b0);
        send_word(OP_PATTERN, 8'hFF, 1'b0);
        send_word(OP_TEXT, 8'hFF, 1'b0);
        send_word(OP_TEXT, 8'hFF, 1'b0);
        send_word(OP_TEXT, 8'h00, 1'b1);
        // A pattern with a border, so that the search falls back along a link.
        send_word(OP_PATTERN, 8'h61, 1'b0);
        send_word(OP_PATTERN, 8'h62, 1'b0);
        send_word(OP_PATTERN, 8'h61, 1'b1);
        send_word(OP_TEXT, 8'h61, 1'b0);
        send_word(OP_TEXT, 8'h61, 1'b0);
        send_word(OP_TEXT, 8'h62, 1'b0);
        send_word(OP_TEXT, 8'h61, 1'b1);
        // The same pattern against a single foreign byte.
        send_word(OP_TEXT, 8'h12, 1'b1);
        // A fresh pattern replaces the closed one.
        send_word(OP_PATTERN, 8'h55, 1'b0);
        send_word(OP_PATTERN, 8'hAA, 1'b1);
        send_word(OP_TEXT, 8'h55, 1'b0);
        send_word(OP_TEXT, 8'hAA, 1'b1);
    endtask

    // One random case. Most cases are a pattern over a tiny alphabet followed by texts over
    // the same alphabet, often with the pattern planted in them, so that the match length
    // climbs and falls back along the links. A few patterns run past the store to reach
    // the exact capacity and the overflow. The rest is noise and loose text.
    task automatic run_random_case();
        logic [SYMBOL_W-1:0] alphabet [3];
        int kind;
        int alpha_n;
        int pat_len;
        int text_len;
        int text_count;
        int plant_at;
        int pick;
        bit close_pat;
        kind = $urandom_range(0, 99);
        if (kind < 80)
        begin
            alpha_n = $urandom_range(1, 3);
            for (int i = 0; i < 3; i++)
                alphabet[i] = SYMBOL_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 88)
                pat_len = $urandom_range(1, 6);
            else if (pick < 96)
                pat_len = $urandom_range(7, 20);
            else
                pat_len = $urandom_range(62, 68);
            pattern_buf.delete();
            for (int i = 0; i < pat_len; i++)
                pattern_buf.push_back(alphabet[$urandom_range(0, alpha_n - 1)]);
            // Now and then the pattern is left open and the first text closes it.
            close_pat = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < pat_len; i++)
                send_word(OP_PATTERN, pattern_buf[i], close_pat && (i == pat_len - 1));
            text_count = $urandom_range(1, 3);
            for (int t = 0; t < text_count; t++)
            begin
                if (pat_len > 20)
                    text_len = pat_len + $urandom_range(0, 20);
                else
                    text_len = $urandom_range(1, 24);
                text_buf.delete();
                for (int i = 0; i < text_len; i++)
                    text_buf.push_back(alphabet[$urandom_range(0, alpha_n - 1)]);
                if ($urandom_range(0, 1) == 1 && pat_len <= text_len)
                begin
                    plant_at = $urandom_range(0, text_len - pat_len);
                    for (int i = 0; i < pat_len; i++)
                        text_buf[plant_at + i] = pattern_buf[i];
                end
                for (int i = 0; i < text_len; i++)
                    send_word(OP_TEXT, text_buf[i], i == text_len - 1);
            end
        end
        else if (kind < 95)
        begin
            pick = $urandom_range(1, 8);
            for (int i = 0; i < pick; i++)
                send_word(($urandom_range(0, 1) == 1) ? OP_TEXT : OP_PATTERN,
                          SYMBOL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        else
        begin
            text_len = $urandom_range(1, 10);
            for (int i = 0; i < text_len; i++)
                send_word(OP_TEXT, SYMBOL_W'($urandom_range(0, 255)), i == text_len - 1);
        end
    endtask

    // Result receiver. Besides the random idling, it once holds ready low for a long
    // stretch while the sender keeps offering words, so that the result register fills
    // and the core has to stall its input.
    initial
    begin
        result_ch.ready = 1'b0;
        hold_left       = 0;
        hold_done       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && words_sent >= HOLD_AT_WORD)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: any accepted word on either channel restarts the count.
    initial
    begin
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((feed_ch.valid && feed_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        feed_ch.valid     = 1'b0;
        feed_ch.operation = OP_PATTERN;
        feed_ch.symbol    = '0;
        feed_ch.last      = 1'b0;
        words_sent        = 0;
        send_idle_pct     = 10;
        recv_idle_pct     = 59;
        rst_n             = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        while (words_sent < WORD_TARGET)
            run_random_case();
        feed_ch.valid <= 1'b0;

        // Let every predicted result arrive, then give the core time to show any extra one.
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
